// ----- rtl/core/rbpb_pkg.sv -----
// Shared types, widths and constants for the radial brush pixel blend.
// Used by every module under rtl/core; depends on nothing.
package rbpb_pkg;

    // Coordinate format: pixel coordinates are integers, the centre is QC.F.
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 8;

    // Distance datapath widths.
    localparam int CW    = COORD_BITS + FRAC_BITS;   // dx, dy in Q.F
    localparam int SQ_W  = 2 * CW + 1;               // dx*dx + dy*dy
    localparam int RT_W  = CW + 1;                   // square root bits
    localparam int V_W   = 2 * RT_W;                 // radicand padded to whole pairs
    localparam int REM_W = RT_W + 2;                 // root remainder

    // Falloff divider widths.
    localparam int DIAM_W = 11;
    localparam int RAD_W  = DIAM_W + FRAC_BITS - 1;  // radius in Q.F
    localparam int DREM_W = RAD_W + 1;
    localparam int FALL_W = 17;                      // Q1.16 up to one
    localparam int DIV_ST = FALL_W - 1;              // quotient bits after the first

    // Blend widths and constants.
    localparam int STR_W = 17;
    localparam int CH_W  = 16;
    localparam int CFG_W = 20;
    localparam int IDX_W = 3;
    localparam int FMT_W = 2;

    localparam logic [STR_W-1:0] ONE_Q16   = 17'h1_0000;
    localparam logic [16:0]      RECIP_257 = 17'd65281;   // ceil(2^24 / 257)
    localparam logic [CH_W-1:0]  ALPHA_8   = 16'h00FF;
    localparam logic [CH_W-1:0]  ALPHA_16  = 16'hFFFF;

    localparam logic [FMT_W-1:0] FMT_8BIT  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_16BIT = 2'd1;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_DIAMETER    = 3'd2,
        REG_STRENGTH    = 3'd3,
        REG_COLOR_RED   = 3'd4,
        REG_COLOR_GREEN = 3'd5,
        REG_COLOR_BLUE  = 3'd6,
        REG_FORMAT      = 3'd7
    } t_reg_idx;

    // Brush settings as held by the configuration registers.
    typedef struct packed {
        logic [CW-1:0]              cx;
        logic [CW-1:0]              cy;
        logic [DIAM_W-1:0]          diam;
        logic [STR_W-1:0]           strength;
        logic [2:0][CH_W-1:0]       col;
        logic [FMT_W-1:0]           fmt;
    } t_brush;

    // Pixel payload that rides alongside the arithmetic.
    typedef struct packed {
        logic [COORD_BITS-1:0]      x;
        logic [COORD_BITS-1:0]      y;
        logic [2:0][CH_W-1:0]       old;
    } t_side;

endpackage

// ----- rtl/core/rbpb_dist.sv -----
// Squared distance from a pixel to the brush centre, three register stages.
// Depends on rbpb_pkg.
module rbpb_dist import rbpb_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  t_side           i_side,
    input  logic [CW-1:0]   i_cx,
    input  logic [CW-1:0]   i_cy,
    output logic            o_vld,
    output t_side           o_side,
    output logic [SQ_W-1:0] o_sq
);

    logic [2:0]        r_vld;
    t_side             r_side [3];
    logic [CW-1:0]     r_dx, r_dy;
    logic [2*CW-1:0]   r_sqx, r_sqy;
    logic [SQ_W-1:0]   r_sq;

    logic [CW-1:0]     n_xq, n_yq, n_dx, n_dy;

    // Absolute offsets in Q.F.
    always_comb begin
        n_xq = {i_side.x, {FRAC_BITS{1'b0}}};
        n_yq = {i_side.y, {FRAC_BITS{1'b0}}};
        n_dx = (n_xq >= i_cx) ? (n_xq - i_cx) : (i_cx - n_xq);
        n_dy = (n_yq >= i_cy) ? (n_yq - i_cy) : (i_cy - n_yq);
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    // Offsets, squares, then their sum.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            r_dx      <= n_dx;
            r_dy      <= n_dy;
            r_sqx     <= r_dx * r_dx;
            r_sqy     <= r_dy * r_dy;
            r_sq      <= {1'b0, r_sqx} + {1'b0, r_sqy};
        end
    end

    assign o_vld  = r_vld[2];
    assign o_side = r_side[2];
    assign o_sq   = r_sq;

endmodule

// ----- rtl/core/rbpb_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Depends on rbpb_pkg.
module rbpb_sqrt import rbpb_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  t_side           i_side,
    input  logic [SQ_W-1:0] i_sq,
    output logic            o_vld,
    output t_side           o_side,
    output logic [RT_W-1:0] o_root
);

    logic [RT_W-1:0]  r_vld;
    t_side            r_side [RT_W];
    logic [REM_W-1:0] r_rem  [RT_W];
    logic [RT_W-1:0]  r_root [RT_W];
    logic [V_W-1:0]   r_v    [RT_W];

    logic [REM_W-1:0] n_rem  [RT_W];
    logic [RT_W-1:0]  n_root [RT_W];
    logic [V_W-1:0]   n_v    [RT_W];

    // One restoring step per stage: bring down two radicand bits, try root*4+1.
    always_comb begin
        logic [REM_W-1:0] pr_rem;
        logic [RT_W-1:0]  pr_root;
        logic [V_W-1:0]   pr_v;
        logic [REM_W-1:0] sh_rem;
        logic [REM_W-1:0] trial;
        logic             ge;
        for (int i = 0; i < RT_W; i++) begin
            if (i == 0) begin
                pr_rem  = '0;
                pr_root = '0;
                pr_v    = {{(V_W-SQ_W){1'b0}}, i_sq};
            end else begin
                pr_rem  = r_rem[i-1];
                pr_root = r_root[i-1];
                pr_v    = r_v[i-1];
            end
            sh_rem    = {pr_rem[REM_W-3:0], pr_v[V_W-1:V_W-2]};
            trial     = {pr_root, 2'b01};
            ge        = (sh_rem >= trial);
            n_rem[i]  = ge ? (sh_rem - trial) : sh_rem;
            n_root[i] = {pr_root[RT_W-2:0], ge};
            n_v[i]    = {pr_v[V_W-3:0], 2'b00};
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[RT_W-2:0], i_vld};
        end
    end

    // Stage registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < RT_W; i++) begin
                r_side[i] <= (i == 0) ? i_side : r_side[(i == 0) ? 0 : i-1];
                r_rem[i]  <= n_rem[i];
                r_root[i] <= n_root[i];
                r_v[i]    <= n_v[i];
            end
        end
    end

    assign o_vld  = r_vld[RT_W-1];
    assign o_side = r_side[RT_W-1];
    assign o_root = r_root[RT_W-1];

endmodule

// ----- rtl/core/rbpb_div.sv -----
// Linear falloff (radius - dist) * 65536 / radius by a pipelined restoring
// divider, one quotient bit per stage. Depends on rbpb_pkg.
module rbpb_div import rbpb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  t_side             i_side,
    input  logic [RT_W-1:0]   i_dist,
    input  logic [DIAM_W-1:0] i_diam,
    output logic              o_vld,
    output t_side             o_side,
    output logic [FALL_W-1:0] o_fall
);

    localparam int ST = DIV_ST + 1;

    logic [ST-1:0]     r_vld;
    t_side             r_side [ST];
    logic [DREM_W-1:0] r_rem  [ST];
    logic [FALL_W-1:0] r_q    [ST];
    logic [ST-1:0]     r_zero;

    logic [DREM_W-1:0] n_rem  [ST];
    logic [FALL_W-1:0] n_q    [ST];
    logic              n_zero;
    logic [RAD_W-1:0]  radius;

    assign radius = {i_diam, {(FRAC_BITS-1){1'b0}}};

    // Stage 0 sets up the remainder; the rest each produce one quotient bit.
    always_comb begin
        logic [DREM_W-1:0] sh;
        logic              ge;
        n_zero   = (radius == '0) || (i_dist >= {{(RT_W-RAD_W){1'b0}}, radius});
        // Integer part of the quotient is one only when the pixel sits on the centre.
        n_q[0]   = {{(FALL_W-1){1'b0}}, (!n_zero && (i_dist == '0))};
        n_rem[0] = (n_zero || (i_dist == '0)) ? '0
                 : {1'b0, radius - i_dist[RAD_W-1:0]};
        for (int i = 1; i < ST; i++) begin
            sh       = {r_rem[i-1][DREM_W-2:0], 1'b0};
            ge       = (sh >= {1'b0, radius});
            n_rem[i] = ge ? (sh - {1'b0, radius}) : sh;
            n_q[i]   = {r_q[i-1][FALL_W-2:0], ge};
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ST-2:0], i_vld};
        end
    end

    // Stage registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero <= {r_zero[ST-2:0], n_zero};
            for (int i = 0; i < ST; i++) begin
                r_side[i] <= (i == 0) ? i_side : r_side[(i == 0) ? 0 : i-1];
                r_rem[i]  <= n_rem[i];
                r_q[i]    <= n_q[i];
            end
        end
    end

    assign o_vld  = r_vld[ST-1];
    assign o_side = r_side[ST-1];
    assign o_fall = r_zero[ST-1] ? '0 : r_q[ST-1];

endmodule

// ----- rtl/core/rbpb_blend.sv -----
// Alpha scaling and per-channel blend toward the brush colour, four stages;
// the last stage is the output register. Depends on rbpb_pkg.
module rbpb_blend import rbpb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  t_side             i_side,
    input  logic [FALL_W-1:0] i_fall,
    input  t_brush            i_brush,
    output logic              o_vld,
    output t_side             o_side,
    output logic [2:0][CH_W-1:0] o_new,
    output logic [CH_W-1:0]   o_alpha,
    output logic              o_modified
);

    logic [3:0]            r_vld;
    t_side                 r_side [3];
    logic [STR_W-1:0]      r_alpha;
    logic signed [35:0]    r_prod [3];
    logic signed [19:0]    r_t    [3];
    logic [33:0]           r_m    [3];
    logic [2:0][CH_W-1:0]  r_new;
    logic [COORD_BITS-1:0] r_ox, r_oy;
    logic [CH_W-1:0]       r_oalpha;
    logic                  r_mod;

    logic [STR_W-1:0]      str_sat;
    logic [2*STR_W-1:0]    n_amul;
    logic signed [35:0]    n_prod [3];
    logic signed [19:0]    n_t    [3];
    logic [33:0]           n_m    [3];
    logic [2:0][CH_W-1:0]  n_new;
    logic                  fmt8, painted;

    assign fmt8    = (i_brush.fmt == FMT_8BIT);
    assign painted = (i_brush.fmt == FMT_8BIT) || (i_brush.fmt == FMT_16BIT);
    assign str_sat = (i_brush.strength > ONE_Q16) ? ONE_Q16 : i_brush.strength;
    assign n_amul  = i_fall * str_sat;

    // Difference to the target times alpha; 257*old is old repeated in both bytes.
    always_comb begin
        logic [CH_W-1:0]    sub;
        logic signed [17:0] d;
        for (int c = 0; c < 3; c++) begin
            sub       = fmt8 ? {r_side[0].old[c][7:0], r_side[0].old[c][7:0]}
                             : r_side[0].old[c];
            d         = $signed({2'b00, i_brush.col[c]}) - $signed({2'b00, sub});
            n_prod[c] = d * $signed({1'b0, r_alpha});
        end
    end

    // Floor by 65536, then magnitude times the reciprocal of 257.
    always_comb begin
        logic [19:0] u;
        for (int c = 0; c < 3; c++) begin
            n_t[c] = r_prod[c][35:16];
            u      = n_t[c][19] ? ((20'd0 - n_t[c]) + 20'd256) : n_t[c];
            n_m[c] = u[16:0] * RECIP_257;
        end
    end

    // Final channel values.
    always_comb begin
        logic [CH_W-1:0] qm;
        logic [CH_W-1:0] q;
        for (int c = 0; c < 3; c++) begin
            qm = {6'b0, r_m[c][33:24]};
            q  = r_t[c][19] ? (16'd0 - qm) : qm;
            if (!painted) begin
                n_new[c] = r_side[2].old[c];
            end else if (fmt8) begin
                n_new[c] = {8'b0, r_side[2].old[c][7:0]} + q;
            end else begin
                n_new[c] = r_side[2].old[c] + r_t[c][15:0];
            end
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    // Stage registers and output register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            r_alpha   <= n_amul[STR_W+15:16];
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= n_prod[c];
                r_t[c]    <= n_t[c];
                r_m[c]    <= n_m[c];
            end
            r_new    <= n_new;
            r_ox     <= r_side[2].x;
            r_oy     <= r_side[2].y;
            r_oalpha <= !painted ? '0 : (fmt8 ? ALPHA_8 : ALPHA_16);
            r_mod    <= painted;
        end
    end

    always_comb begin
        o_side     = '0;
        o_side.x   = r_ox;
        o_side.y   = r_oy;
        o_side.old = r_new;
    end

    assign o_vld      = r_vld[3];
    assign o_new      = r_new;
    assign o_alpha    = r_oalpha;
    assign o_modified = r_mod;

endmodule

// ----- rtl/core/radial_brush_pixel_blend_top.sv -----
// Radial brush pixel blend: configuration registers and the pipeline chain.
// Depends on rbpb_pkg, rbpb_dist, rbpb_sqrt, rbpb_div and rbpb_blend.

// The block takes one pixel beat per clock while o_in_ready is high and returns one
// result beat per pixel, in order, through 3 distance stages, 21 square root stages,
// 17 divider stages and 4 blend stages; the whole pipeline advances together, so a
// stalled output holds every stage and input ready drops in the same cycle. Write the
// configuration registers only while the pipeline is empty.
module radial_brush_pixel_blend_top import rbpb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    input  logic [CH_W-1:0]       i_old_red,
    input  logic [CH_W-1:0]       i_old_green,
    input  logic [CH_W-1:0]       i_old_blue,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COORD_BITS-1:0] o_out_x,
    output logic [COORD_BITS-1:0] o_out_y,
    output logic [CH_W-1:0]       o_new_red,
    output logic [CH_W-1:0]       o_new_green,
    output logic [CH_W-1:0]       o_new_blue,
    output logic [CH_W-1:0]       o_new_alpha,
    output logic                  o_modified
);

    t_brush r_brush;
    logic   en;
    t_side  in_side, d_side, s_side, v_side, b_side;
    logic   d_vld, s_vld, v_vld, b_vld;
    logic [SQ_W-1:0]      d_sq;
    logic [RT_W-1:0]      s_root;
    logic [FALL_W-1:0]    v_fall;
    logic [2:0][CH_W-1:0] b_new;
    logic [CH_W-1:0]      b_alpha;
    logic                 b_mod;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brush.cx       <= '0;
            r_brush.cy       <= '0;
            r_brush.diam     <= 11'd16;
            r_brush.strength <= ONE_Q16;
            r_brush.col      <= {3{16'hFFFF}};
            r_brush.fmt      <= FMT_8BIT;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_CENTER_X:    r_brush.cx       <= i_cfg_data[CW-1:0];
                REG_CENTER_Y:    r_brush.cy       <= i_cfg_data[CW-1:0];
                REG_DIAMETER:    r_brush.diam     <= i_cfg_data[DIAM_W-1:0];
                REG_STRENGTH:    r_brush.strength <= i_cfg_data[STR_W-1:0];
                REG_COLOR_RED:   r_brush.col[0]   <= i_cfg_data[CH_W-1:0];
                REG_COLOR_GREEN: r_brush.col[1]   <= i_cfg_data[CH_W-1:0];
                REG_COLOR_BLUE:  r_brush.col[2]   <= i_cfg_data[CH_W-1:0];
                REG_FORMAT:      r_brush.fmt      <= i_cfg_data[FMT_W-1:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline moves when the output register is free or being taken.
    assign en         = !b_vld || i_out_ready;
    assign o_in_ready = en;

    always_comb begin
        in_side.x      = i_pixel_x;
        in_side.y      = i_pixel_y;
        in_side.old[0] = i_old_red;
        in_side.old[1] = i_old_green;
        in_side.old[2] = i_old_blue;
    end

    rbpb_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in_valid),
        .i_side  (in_side),
        .i_cx    (r_brush.cx),
        .i_cy    (r_brush.cy),
        .o_vld   (d_vld),
        .o_side  (d_side),
        .o_sq    (d_sq)
    );

    rbpb_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (d_vld),
        .i_side  (d_side),
        .i_sq    (d_sq),
        .o_vld   (s_vld),
        .o_side  (s_side),
        .o_root  (s_root)
    );

    rbpb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_vld),
        .i_side  (s_side),
        .i_dist  (s_root),
        .i_diam  (r_brush.diam),
        .o_vld   (v_vld),
        .o_side  (v_side),
        .o_fall  (v_fall)
    );

    rbpb_blend u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (v_vld),
        .i_side     (v_side),
        .i_fall     (v_fall),
        .i_brush    (r_brush),
        .o_vld      (b_vld),
        .o_side     (b_side),
        .o_new      (b_new),
        .o_alpha    (b_alpha),
        .o_modified (b_mod)
    );

    assign o_out_valid = b_vld;
    assign o_out_x     = b_side.x;
    assign o_out_y     = b_side.y;
    assign o_new_red   = b_new[0];
    assign o_new_green = b_new[1];
    assign o_new_blue  = b_new[2];
    assign o_new_alpha = b_alpha;
    assign o_modified  = b_mod;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for radial_brush_pixel_blend_top.
// Depends on rbpb_pkg and the block's RTL; holds its own blend predictor.
module tb;
    import rbpb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } t_pixel;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [15:0] a;
        logic        m;
    } t_blended;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [11:0]       i_pixel_x = '0;
    logic [11:0]       i_pixel_y = '0;
    logic [15:0]       i_old_red = '0;
    logic [15:0]       i_old_green = '0;
    logic [15:0]       i_old_blue = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [11:0]       o_out_x;
    logic [11:0]       o_out_y;
    logic [15:0]       o_new_red;
    logic [15:0]       o_new_green;
    logic [15:0]       o_new_blue;
    logic [15:0]       o_new_alpha;
    logic              o_modified;

    radial_brush_pixel_blend_top uut (.*);

    always #5 i_clk = ~i_clk;

    // Brush settings as the predictor sees them.
    logic [19:0] brush_cx;
    logic [19:0] brush_cy;
    logic [10:0] brush_diam;
    logic [16:0] brush_gain;
    logic [15:0] brush_col [3];
    logic [1:0]  brush_fmt;

    t_pixel   pixel_q [$];
    t_blended blended_q [$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_off = 0;
    bit       failed = 1'b0;
    bit       stim_done = 1'b0;
    longint   cycles = 0;
    logic     o_in_ready_q = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint floor_div(longint num, longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // Alpha in Q1.16 from distance falloff and strength.
    function automatic longint unsigned brush_alpha(logic [11:0] px, logic [11:0] py);
        longint unsigned xq, yq, dx, dy, span, radius, fall, str;
        xq = longint'(px) << 8;
        yq = longint'(py) << 8;
        dx = (xq >= brush_cx) ? xq - brush_cx : brush_cx - xq;
        dy = (yq >= brush_cy) ? yq - brush_cy : brush_cy - yq;
        span = int_sqrt(dx * dx + dy * dy);
        radius = longint'(brush_diam) << 7;
        if (radius == 0 || span >= radius) return 0;
        fall = ((radius - span) * 65536) / radius;
        str = (brush_gain > ONE_Q16) ? 65536 : brush_gain;
        return (fall * str) >> 16;
    endfunction

    function automatic t_blended blend_pixel(t_pixel p);
        t_blended res;
        longint alpha, oldv, nv;
        logic [15:0] olds [3];
        logic [15:0] news [3];
        olds[0] = p.r;
        olds[1] = p.g;
        olds[2] = p.b;
        res.x = p.x;
        res.y = p.y;
        if (brush_fmt != FMT_8BIT && brush_fmt != FMT_16BIT) begin
            res.r = p.r;
            res.g = p.g;
            res.b = p.b;
            res.a = '0;
            res.m = 1'b0;
            return res;
        end
        alpha = longint'(brush_alpha(p.x, p.y));
        for (int c = 0; c < 3; c++) begin
            if (brush_fmt == FMT_8BIT) begin
                oldv = longint'(olds[c][7:0]);
                nv = oldv + floor_div((longint'(brush_col[c]) - 257 * oldv) * alpha,
                                      longint'(257) * 65536);
            end else begin
                oldv = longint'(olds[c]);
                nv = oldv + floor_div((longint'(brush_col[c]) - oldv) * alpha, 65536);
            end
            news[c] = nv[15:0];
        end
        res.r = news[0];
        res.g = news[1];
        res.b = news[2];
        res.a = (brush_fmt == FMT_8BIT) ? ALPHA_8 : ALPHA_16;
        res.m = 1'b1;
        return res;
    endfunction

    // Driver: offer the next pending pixel, predict its result on acceptance.
    always @(negedge i_clk) begin
        if (i_in_valid && o_in_ready_q) begin
            blended_q.push_back(blend_pixel(pixel_q.pop_front()));
        end
        if (!(i_in_valid && !o_in_ready_q)) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_pixel_x <= pixel_q[0].x;
                i_pixel_y <= pixel_q[0].y;
                i_old_red <= pixel_q[0].r;
                i_old_green <= pixel_q[0].g;
                i_old_blue <= pixel_q[0].b;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off counted down here.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Ready as seen at the last rising edge, so acceptance is judged from sampled values.
    always @(posedge i_clk) o_in_ready_q <= o_in_ready;

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_blended exp_b;
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("Timeout at %0t", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (blended_q.size() == 0) begin
                $display("%0t: unexpected beat x=%0d y=%0d", $time, o_out_x, o_out_y);
                failed = 1'b1;
            end else begin
                exp_b = blended_q.pop_front();
                if ({o_out_x, o_out_y, o_new_red, o_new_green, o_new_blue, o_new_alpha,
                     o_modified} !== {exp_b.x, exp_b.y, exp_b.r, exp_b.g, exp_b.b,
                     exp_b.a, exp_b.m}) begin
                    $display("%0t: expected x=%0d y=%0d rgb=%h %h %h a=%h m=%b", $time,
                             exp_b.x, exp_b.y, exp_b.r, exp_b.g, exp_b.b, exp_b.a, exp_b.m);
                    $display("%0t: actual   x=%0d y=%0d rgb=%h %h %h a=%h m=%b", $time,
                             o_out_x, o_out_y, o_new_red, o_new_green, o_new_blue,
                             o_new_alpha, o_modified);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [19:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_CENTER_X:    brush_cx = val;
            REG_CENTER_Y:    brush_cy = val;
            REG_DIAMETER:    brush_diam = val[10:0];
            REG_STRENGTH:    brush_gain = val[16:0];
            REG_COLOR_RED:   brush_col[0] = val[15:0];
            REG_COLOR_GREEN: brush_col[1] = val[15:0];
            REG_COLOR_BLUE:  brush_col[2] = val[15:0];
            REG_FORMAT:      brush_fmt = val[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_pixel(logic [11:0] x, logic [11:0] y, logic [15:0] r,
                             logic [15:0] g, logic [15:0] b);
        t_pixel p;
        p.x = x;
        p.y = y;
        p.r = r;
        p.g = g;
        p.b = b;
        pixel_q.push_back(p);
    endtask

    // Wait until every pixel is accepted and every result checked, then let the pipe drain.
    task automatic drain();
        while (pixel_q.size() > 0 || i_in_valid || blended_q.size() > 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // Pixels mostly near the centre so the falloff is exercised.
    task automatic random_pixels(int n);
        int cx, cy, d;
        for (int k = 0; k < n; k++) begin
            cx = brush_cx >> 8;
            cy = brush_cy >> 8;
            d = brush_diam / 2 + 2;
            if ($urandom_range(9) < 8)
                add_pixel(12'(cx + $urandom_range(2 * d) - d), 12'(cy + $urandom_range(2 * d) - d),
                          16'($urandom), 16'($urandom), 16'($urandom));
            else
                add_pixel(12'($urandom), 12'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom));
        end
    endtask

    task automatic random_brush();
        write_reg(REG_CENTER_X, 20'($urandom_range(40 * 256, 4000 * 256)));
        write_reg(REG_CENTER_Y, 20'($urandom_range(40 * 256, 4000 * 256)));
        write_reg(REG_DIAMETER, 20'($urandom_range(0, 60)));
        write_reg(REG_STRENGTH, 20'($urandom_range(0, 131071)));
        write_reg(REG_COLOR_RED, 20'($urandom_range(0, 65535)));
        write_reg(REG_COLOR_GREEN, 20'($urandom_range(0, 65535)));
        write_reg(REG_COLOR_BLUE, 20'($urandom_range(0, 65535)));
        write_reg(REG_FORMAT, 20'($urandom_range(0, 3)));
    endtask

    initial begin
        brush_cx = 0;
        brush_cy = 0;
        brush_diam = 16;
        brush_gain = 17'h10000;
        brush_col[0] = 16'hFFFF;
        brush_col[1] = 16'hFFFF;
        brush_col[2] = 16'hFFFF;
        brush_fmt = FMT_8BIT;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset brush, corner pixels, wide 8-bit channels.
        add_pixel(12'd0, 12'd0, 16'h0000, 16'h00FF, 16'hFF80);
        add_pixel(12'd3, 12'd4, 16'hFFFF, 16'h1234, 16'h0001);
        add_pixel(12'hFFF, 12'hFFF, 16'h0055, 16'hAA00, 16'h7F7F);
        drain();
        // Centre at the field maximum, 16-bit, diameter 1024, excess strength.
        write_reg(REG_CENTER_X, 20'hFFFFF);
        write_reg(REG_CENTER_Y, 20'hFFFFF);
        write_reg(REG_DIAMETER, 20'd1024);
        write_reg(REG_STRENGTH, 20'h1FFFF);
        write_reg(REG_COLOR_RED, 20'd0);
        write_reg(REG_COLOR_GREEN, 20'hFFFF);
        write_reg(REG_COLOR_BLUE, 20'h8000);
        write_reg(REG_FORMAT, 20'(FMT_16BIT));
        add_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 16'h0000, 16'h1234);
        add_pixel(12'hE00, 12'hF00, 16'hAAAA, 16'h5555, 16'hFFFF);
        add_pixel(12'd0, 12'd0, 16'hFFFF, 16'h0000, 16'h0000);
        add_pixel(12'h800, 12'hFFF, 16'h0000, 16'hFFFF, 16'h8000);
        drain();
        // Zero diameter, minimum strength, unpainted formats.
        write_reg(REG_DIAMETER, 20'd0);
        add_pixel(12'hFFF, 12'hFFF, 16'h1111, 16'h2222, 16'h3333);
        drain();
        write_reg(REG_DIAMETER, 20'd1);
        write_reg(REG_STRENGTH, 20'd0);
        add_pixel(12'hFFF, 12'hFFF, 16'h1111, 16'h2222, 16'h3333);
        drain();
        write_reg(REG_STRENGTH, 20'd65536);
        write_reg(REG_FORMAT, 20'd2);
        add_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 16'h0000, 16'hABCD);
        drain();
        write_reg(REG_FORMAT, 20'd3);
        add_pixel(12'h123, 12'h456, 16'h0F0F, 16'hF0F0, 16'h0001);
        drain();

        // Random phases with varying idling and brush settings.
        for (int ph = 0; ph < 8; ph++) begin
            random_brush();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            if (ph == 4) hold_off = 300;
            random_pixels(50);
            drain();
        end

        if (!failed) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ----- radial_brush_pixel_blend_top.f -----
rtl/core/rbpb_pkg.sv
rtl/core/rbpb_dist.sv
rtl/core/rbpb_sqrt.sv
rtl/core/rbpb_div.sv
rtl/core/rbpb_blend.sv
rtl/core/radial_brush_pixel_blend_top.sv
tb/tb.sv
